@@ sv/lagrange_interpolator_core_assert.svh @@
// Assertion macros for the Lagrange interpolator core.
// Used by lagrange_interpolator_core.sv; expects clk and arst_n in scope.
`ifndef LAGRANGE_INTERPOLATOR_CORE_ASSERT_SVH
`define LAGRANGE_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LGI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define LGI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lgi_pkg.sv @@
// Shared constants and controller/datapath interface types for the Lagrange interpolator.
// No dependencies.
package lgi_pkg;

	localparam int MaxPointsDef = 8;
	localparam int FracBitsDef  = 16;
	localparam int DataW        = 32;
	localparam int DiffW        = 33;
	localparam int StatusW      = 2;

	localparam logic [StatusW-1:0] ST_OK  = 2'd0;
	localparam logic [StatusW-1:0] ST_DUP = 2'd1;
	localparam logic [StatusW-1:0] ST_OVF = 2'd2;
	localparam logic [StatusW-1:0] ST_SAT = 2'd3;

	typedef struct packed {
		logic wr_en;
		logic start;
		logic w_init;
		logic div_start;
		logic rsat_en;
		logic mul_en;
		logic mul_sel_ratio;
		logic rnd_en;
		logic sat_w;
		logic sat_term;
		logic out_load;
		logic ovf;
	} lgi_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} lgi_sts_t;

endpackage

@@ sv/lgi_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lgi_pkg.
module lgi_div #(
	parameter int NUM_W = 49
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUM_W-1:0]          dividend,
	input  logic [lgi_pkg::DiffW-1:0] divisor,
	output logic                      busy,
	output logic [NUM_W-1:0]          quot
);
	import lgi_pkg::*;

	localparam int CntW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CntW-1:0]  cnt_q;
	logic [DiffW-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DiffW:0]   trial;
	logic [DiffW:0]   diff;
	logic             ge;

	// Trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CntW'(1);
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DiffW-1:0] : trial[DiffW-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

@@ sv/lgi_ctrl.sv @@
// Controller state machine: node loading and the basis/term evaluation sequence.
// Depends on lgi_pkg.
module lgi_ctrl #(
	parameter int MAX_POINTS = lgi_pkg::MaxPointsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_last,
	output logic                          in_ready,
	input  lgi_pkg::lgi_sts_t             sts,
	output lgi_pkg::lgi_cmd_t             cmd,
	output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
	output logic [$clog2(MAX_POINTS)-1:0] rd_a,
	output logic [$clog2(MAX_POINTS)-1:0] rd_b
);
	import lgi_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ISTART = 4'd1;
	localparam logic [3:0] S_NCHK   = 4'd2;
	localparam logic [3:0] S_RD     = 4'd3;
	localparam logic [3:0] S_DSTART = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_RSAT   = 4'd6;
	localparam logic [3:0] S_MUL    = 4'd7;
	localparam logic [3:0] S_RND    = 4'd8;
	localparam logic [3:0] S_WSAT   = 4'd9;
	localparam logic [3:0] S_TRD    = 4'd10;
	localparam logic [3:0] S_TMUL   = 4'd11;
	localparam logic [3:0] S_TRND   = 4'd12;
	localparam logic [3:0] S_TSAT   = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] n_q;
	logic          ovf_q;
	logic          room;

	assign room     = cnt_q < CW'(MAX_POINTS);
	assign in_ready = (state_q == S_IDLE);
	assign wr_addr  = cnt_q[IW-1:0];
	assign rd_a     = i_q[IW-1:0];
	assign rd_b     = n_q[IW-1:0];

	// Decode commands from state
	always_comb begin
		cmd     = '0;
		cmd.ovf = ovf_q;
		case (state_q)
			S_IDLE: begin
				cmd.wr_en = in_valid && room;
				cmd.start = in_valid && in_last;
			end
			S_ISTART: cmd.w_init = 1'b1;
			S_DSTART: cmd.div_start = 1'b1;
			S_RSAT:   cmd.rsat_en = 1'b1;
			S_MUL: begin
				cmd.mul_en        = 1'b1;
				cmd.mul_sel_ratio = 1'b1;
			end
			S_TMUL:   cmd.mul_en = 1'b1;
			S_RND:    cmd.rnd_en = 1'b1;
			S_TRND:   cmd.rnd_en = 1'b1;
			S_WSAT:   cmd.sat_w = 1'b1;
			S_TSAT:   cmd.sat_term = 1'b1;
			S_DONE:   cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			i_q     <= '0;
			n_q     <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							i_q     <= '0;
							state_q <= S_ISTART;
						end
					end
				end
				S_ISTART: begin
					n_q     <= '0;
					state_q <= S_NCHK;
				end
				S_NCHK: begin
					if (n_q == cnt_q) begin
						state_q <= S_TRD;
					end else if (n_q == i_q) begin
						n_q <= n_q + CW'(1);
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD:     state_q <= S_DSTART;
				S_DSTART: state_q <= S_DIV;
				S_DIV: begin
					if (!sts.div_busy) begin
						state_q <= S_RSAT;
					end
				end
				S_RSAT:   state_q <= S_MUL;
				S_MUL:    state_q <= S_RND;
				S_RND:    state_q <= S_WSAT;
				S_WSAT: begin
					n_q     <= n_q + CW'(1);
					state_q <= S_NCHK;
				end
				S_TRD:    state_q <= S_TMUL;
				S_TMUL:   state_q <= S_TRND;
				S_TRND:   state_q <= S_TSAT;
				S_TSAT: begin
					if ((i_q + CW'(1)) == cnt_q) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_ISTART;
					end
				end
				S_DONE: begin
					if (sts.out_free) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/lgi_dp.sv @@
// Datapath: node stores, ratio divider, shared multiplier, rounding, accumulation, output.
// Depends on lgi_pkg and lgi_div.
module lgi_dp #(
	parameter int MAX_POINTS = lgi_pkg::MaxPointsDef,
	parameter int FRAC_BITS  = lgi_pkg::FracBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lgi_pkg::lgi_cmd_t             cmd,
	output lgi_pkg::lgi_sts_t             sts,
	input  logic [3*lgi_pkg::DataW-1:0]   in_data,
	input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
	input  logic [$clog2(MAX_POINTS)-1:0] rd_a,
	input  logic [$clog2(MAX_POINTS)-1:0] rd_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lgi_pkg::DataW-1:0]     out_value,
	output logic [lgi_pkg::StatusW-1:0]   out_status
);
	import lgi_pkg::*;

	localparam int SW   = DataW + $clog2(MAX_POINTS + 1);
	localparam int NUMW = DiffW + FRAC_BITS;
	localparam int RW   = 2 * DataW - FRAC_BITS;
	localparam logic [DataW-1:0] QMax = {1'b0, {(DataW-1){1'b1}}};
	localparam logic [DataW-1:0] QMin = {1'b1, {(DataW-1){1'b0}}};

	logic signed [DataW-1:0] pos_mem [MAX_POINTS];
	logic signed [DataW-1:0] val_mem [MAX_POINTS];

	logic signed [DataW-1:0]   xa_q, xb_q, ya_q, q_q;
	logic signed [DataW-1:0]   w_q, ratio_q;
	logic [DiffW-1:0]          den_mag_q;
	logic                      qneg_q, dup_q, clip_q, rneg_q;
	logic signed [2*DataW-1:0] prod_s1;
	logic [RW-1:0]             rmag_q;
	logic signed [SW-1:0]      sum_q;
	logic                      out_valid_q;
	logic [DataW-1:0]          out_value_q;
	logic [StatusW-1:0]        out_status_q;

	logic [DiffW-1:0]          dnum, dden, dnum_mag, dden_mag;
	logic [NUMW-1:0]           num_mag, quot, qlim;
	logic                      div_busy, q_over, r_over, s_fits;
	logic [DataW-1:0]          qval, rval, fval;
	logic [RW-1:0]             rlim;
	logic signed [DataW-1:0]   mul_b;
	logic [2*DataW-1:0]        pmag, psum;
	logic [SW-DataW:0]         s_hi;

	// Store nodes and read them back through registered ports
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			pos_mem[wr_addr] <= in_data[DataW-1:0];
			val_mem[wr_addr] <= in_data[2*DataW-1:DataW];
		end
		xa_q <= pos_mem[rd_a];
		xb_q <= pos_mem[rd_b];
		ya_q <= val_mem[rd_a];
		if (cmd.start) begin
			q_q <= in_data[3*DataW-1:2*DataW];
		end
	end

	// Differences and their magnitudes
	always_comb begin
		dnum     = {q_q[DataW-1], q_q} - {xb_q[DataW-1], xb_q};
		dden     = {xa_q[DataW-1], xa_q} - {xb_q[DataW-1], xb_q};
		dnum_mag = dnum[DiffW-1] ? (~dnum + DiffW'(1)) : dnum;
		dden_mag = dden[DiffW-1] ? (~dden + DiffW'(1)) : dden;
		num_mag  = {dnum_mag, {FRAC_BITS{1'b0}}};
	end

	lgi_div #(
		.NUM_W(NUMW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(num_mag),
		.divisor (den_mag_q),
		.busy    (div_busy),
		.quot    (quot)
	);

	// Saturate the signed quotient
	always_comb begin
		qlim   = qneg_q ? NUMW'({1'b1, {(DataW-1){1'b0}}}) : NUMW'(QMax);
		q_over = quot > qlim;
		if (q_over) begin
			qval = qneg_q ? QMin : QMax;
		end else begin
			qval = qneg_q ? (~quot[DataW-1:0] + DataW'(1)) : quot[DataW-1:0];
		end
	end

	// Round half away from zero and saturate
	always_comb begin
		mul_b = cmd.mul_sel_ratio ? ratio_q : ya_q;
		pmag  = prod_s1[2*DataW-1] ? (~prod_s1 + 64'(1)) : prod_s1;
		psum  = pmag + (64'(1) << (FRAC_BITS - 1));
		rlim  = rneg_q ? RW'({1'b1, {(DataW-1){1'b0}}}) : RW'(QMax);
		r_over = rmag_q > rlim;
		if (r_over) begin
			rval = rneg_q ? QMin : QMax;
		end else begin
			rval = rneg_q ? (~rmag_q[DataW-1:0] + DataW'(1)) : rmag_q[DataW-1:0];
		end
	end

	// Final sum saturation
	always_comb begin
		s_hi   = sum_q[SW-1:DataW-1];
		s_fits = (&s_hi) || !(|s_hi);
		fval   = s_fits ? sum_q[DataW-1:0] : (sum_q[SW-1] ? QMin : QMax);
	end

	// Arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			den_mag_q <= dden_mag;
			qneg_q    <= dnum[DiffW-1] ^ dden[DiffW-1];
		end
		if (cmd.rsat_en) begin
			ratio_q <= qval;
		end
		if (cmd.w_init) begin
			w_q <= DataW'(1) << FRAC_BITS;
		end else if (cmd.sat_w) begin
			w_q <= rval;
		end
		if (cmd.mul_en) begin
			prod_s1 <= w_q * mul_b;
		end
		if (cmd.rnd_en) begin
			rneg_q <= prod_s1[2*DataW-1];
			rmag_q <= psum[2*DataW-1:FRAC_BITS];
		end
		if (cmd.start) begin
			sum_q <= '0;
		end else if (cmd.sat_term) begin
			sum_q <= sum_q + {{(SW-DataW){rval[DataW-1]}}, rval};
		end
		if (cmd.out_load) begin
			out_value_q <= dup_q ? '0 : fval;
			if (dup_q) begin
				out_status_q <= ST_DUP;
			end else if (cmd.ovf) begin
				out_status_q <= ST_OVF;
			end else if (clip_q || !s_fits) begin
				out_status_q <= ST_SAT;
			end else begin
				out_status_q <= ST_OK;
			end
		end
	end

	// Sticky duplicate and clip flags, output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q       <= 1'b0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				dup_q  <= 1'b0;
				clip_q <= 1'b0;
			end else begin
				if (cmd.div_start && (xa_q == xb_q)) begin
					dup_q <= 1'b1;
				end
				if ((cmd.rsat_en && q_over) || ((cmd.sat_w || cmd.sat_term) && r_over)) begin
					clip_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_status   = out_status_q;

endmodule

@@ sv/lagrange_interpolator_core.sv @@
// Lagrange polynomial interpolator, signed fixed point with FRAC_BITS fraction bits in
// 32 bits. Each slave transaction loads one node (position, value); the
// transaction with tlast also carries the query position and starts evaluation, after
// which one result leaves on the master side. The ratios of all basis factors come from
// one bit-serial ratio divider (FRAC_BITS+33 steps per ratio). No node is accepted while
// an evaluation runs; a finished result waits in the output register. Status: 0 ok,
// 1 duplicate node positions (value 0), 2 more than MAX_POINTS nodes (extra dropped),
// 3 some intermediate or the final value saturated.
module lagrange_interpolator_core #(
	parameter int MAX_POINTS = lgi_pkg::MaxPointsDef,
	parameter int FRAC_BITS  = lgi_pkg::FracBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// node_pos [31:0], node_val [63:32], query_pos [95:64]
	input  logic [3*lgi_pkg::DataW-1:0]   s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// value [31:0]
	output logic [lgi_pkg::DataW-1:0]     m_axis_tdata,
	// status [1:0]
	output logic [lgi_pkg::StatusW-1:0]   m_axis_tuser
);
	import lgi_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);

	lgi_cmd_t      cmd;
	lgi_sts_t      sts;
	logic [IW-1:0] wr_addr, rd_a, rd_b;

	lgi_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_last (s_axis_tlast),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_a    (rd_a),
		.rd_b    (rd_b)
	);

	lgi_dp #(
		.MAX_POINTS(MAX_POINTS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.wr_addr   (wr_addr),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata),
		.out_status(m_axis_tuser)
	);

`include "lagrange_interpolator_core_assert.svh"

	`LGI_ASSERT_IMP(a_no_accept_in_div, sts.div_busy, !s_axis_tready, "node accepted during divide")
	`LGI_ASSERT_NXT(a_div_runs, cmd.div_start, sts.div_busy, "divider did not start")
	`LGI_ASSERT_IMP(a_load_slot_free, cmd.out_load, sts.out_free, "result overwrote pending output")

endmodule
